// ----- rtl/smc_pkg.sv -----
// shared constants and widths for the subsequence match counter
package smc_pkg;

    // text capacity, alphabet size and match counter width
    localparam int MAX_TEXT    = 1024;
    localparam int ALPHABET    = 26;
    localparam int COUNT_WIDTH = 16;

    // derived widths
    localparam int LTR_W     = 5;
    localparam int LEN_W     = $clog2(MAX_TEXT + 1);
    localparam int TXT_AW    = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int COL_W     = $clog2(ALPHABET);
    localparam int TBL_DEPTH = (MAX_TEXT + 1) * ALPHABET;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    // input opcodes
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_WORD = 1'b1;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BINIT = 3'd1;
    localparam logic [2:0] ST_BRD   = 3'd2;
    localparam logic [2:0] ST_BROW  = 3'd3;
    localparam logic [2:0] ST_LOOK  = 3'd4;
    localparam logic [2:0] ST_EVAL  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

endpackage

// ----- rtl/smc_ram.sv -----
// simple dual port ram with registered read data
module smc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/subsequence_match_counter.sv -----
// top level: text load, next-occurrence table build and word lookup sequencer
// A text letter is taken in the idle state; a text's last letter then starts a table build
// (one table entry per cycle within a row on the single write port, one text read per row).
// A word letter passes accept, table read and evaluate, or is only accepted once the word has
// failed or the letter cannot match; after the last letter the result word is loaded once the
// previous result word has been taken. Synchronous active-low reset clears control state;
// memories are not cleared.
module subsequence_match_counter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [smc_pkg::LTR_W-1:0]         i_letter,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_matched,
    output logic [smc_pkg::COUNT_WIDTH-1:0]   o_match_count,
    output logic                              o_text_overflow
);
    import smc_pkg::*;

    logic [2:0]             r_state;
    logic [LEN_W-1:0]       r_len;
    logic                   r_complete;
    logic [LEN_W-1:0]       r_wp;
    logic                   r_failed;
    logic [COUNT_WIDTH-1:0] r_matches;
    logic                   r_ov;
    logic                   r_last;
    logic [TBL_AW-1:0]      r_taddr;
    logic [LEN_W-1:0]       r_pos;
    logic [TBL_AW-1:0]      r_base;
    logic [COL_W-1:0]       r_col;
    logic                   r_top;
    logic [LEN_W-1:0]       r_nxt [ALPHABET];

    logic                   in_acc;
    logic [LEN_W-1:0]       eff_len;
    logic                   txt_room;
    logic                   ltr_ok;
    logic [LTR_W-1:0]       txt_q;
    logic [LEN_W-1:0]       tbl_q;
    logic [LEN_W-1:0]       row_val;
    logic                   txt_we;
    logic                   txt_re;
    logic                   tbl_we;
    logic                   tbl_re;
    logic [TBL_AW-1:0]      tbl_waddr;
    logic                   out_free;

    // handshake and helpers
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign eff_len    = r_complete ? '0 : r_len;
    assign txt_room   = (eff_len < LEN_W'(MAX_TEXT));
    assign ltr_ok     = ({1'b0, i_letter} < (LTR_W + 1)'(ALPHABET));
    assign out_free   = !o_out_valid || i_out_ready;

    // table row entry: this position for its own letter, else the carried next
    assign row_val = (!r_top && (LTR_W'(r_col) == txt_q)) ? r_pos : r_nxt[r_col];

    // memory controls
    assign txt_we    = in_acc && (i_opcode == OP_TEXT) && txt_room;
    assign txt_re    = (r_state == ST_BRD);
    assign tbl_we    = (r_state == ST_BROW);
    assign tbl_re    = (r_state == ST_LOOK);
    assign tbl_waddr = r_base + TBL_AW'(r_col);

    smc_ram #(
        .DEPTH (MAX_TEXT),
        .WIDTH (LTR_W)
    ) u_text (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (eff_len[TXT_AW-1:0]),
        .i_wdata (i_letter),
        .i_re    (txt_re),
        .i_raddr (r_pos[TXT_AW-1:0]),
        .o_rdata (txt_q)
    );

    smc_ram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH (LEN_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (row_val),
        .i_re    (tbl_re),
        .i_raddr (r_taddr),
        .o_rdata (tbl_q)
    );

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_complete  <= 1'b1;
            r_wp        <= '0;
            r_failed    <= 1'b0;
            r_matches   <= '0;
            r_ov        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // result word taken; a reload in the final state keeps it valid
            if (o_out_valid && i_out_ready && (r_state != ST_FIN)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_opcode == OP_TEXT)) begin
                        // text letter: start a new text if the last one was done
                        if (r_complete) begin
                            r_matches <= '0;
                        end
                        r_ov       <= (r_complete ? 1'b0 : r_ov) | !txt_room;
                        r_len      <= txt_room ? eff_len + LEN_W'(1) : eff_len;
                        r_complete <= 1'b0;
                        r_wp       <= '0;
                        r_failed   <= 1'b0;
                        if (i_last) begin
                            r_state <= ST_BINIT;
                        end
                    end else if (in_acc && r_complete) begin
                        // word letter against a complete text
                        r_last <= i_last;
                        if (r_failed) begin
                            r_state <= i_last ? ST_FIN : ST_IDLE;
                        end else if (!ltr_ok || (r_wp >= r_len)) begin
                            r_failed <= 1'b1;
                            r_state  <= i_last ? ST_FIN : ST_IDLE;
                        end else begin
                            r_taddr <= TBL_AW'(r_wp) * TBL_AW'(ALPHABET)
                                       + TBL_AW'(i_letter);
                            r_state <= ST_LOOK;
                        end
                    end
                end
                ST_BINIT: begin
                    // top row holds none for every letter
                    for (int c = 0; c < ALPHABET; c++) begin
                        r_nxt[c] <= r_len;
                    end
                    r_pos   <= r_len;
                    r_base  <= TBL_AW'(r_len) * TBL_AW'(ALPHABET);
                    r_col   <= '0;
                    r_top   <= 1'b1;
                    r_state <= ST_BROW;
                end
                ST_BRD: begin
                    // text letter of this row is read here
                    r_col   <= '0;
                    r_state <= ST_BROW;
                end
                ST_BROW: begin
                    // one table entry per cycle
                    r_nxt[r_col] <= row_val;
                    if (r_col == COL_W'(ALPHABET - 1)) begin
                        r_top <= 1'b0;
                        if (r_pos == '0) begin
                            r_complete <= 1'b1;
                            r_state    <= ST_IDLE;
                        end else begin
                            r_pos   <= r_pos - LEN_W'(1);
                            r_base  <= r_base - TBL_AW'(ALPHABET);
                            r_state <= ST_BRD;
                        end
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                ST_LOOK: begin
                    r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    // next occurrence found or none
                    if (tbl_q >= r_len) begin
                        r_failed <= 1'b1;
                    end else begin
                        r_wp <= tbl_q + LEN_W'(1);
                    end
                    r_state <= r_last ? ST_FIN : ST_IDLE;
                end
                ST_FIN: begin
                    // load the result word once the output register is free
                    if (out_free) begin
                        o_out_valid     <= 1'b1;
                        o_matched       <= !r_failed;
                        o_text_overflow <= r_ov;
                        if (!r_failed && (r_matches != '1)) begin
                            r_matches     <= r_matches + COUNT_WIDTH'(1);
                            o_match_count <= r_matches + COUNT_WIDTH'(1);
                        end else begin
                            o_match_count <= r_matches;
                        end
                        r_wp     <= '0;
                        r_failed <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the subsequence match counter
`timescale 1ns / 100ps

module testbench;
    import smc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_ITEMS  = 1900;

    typedef struct {
        logic             op;
        logic [LTR_W-1:0] ltr;
        logic             lst;
    } t_letter;

    typedef struct {
        logic                   matched;
        logic [COUNT_WIDTH-1:0] count;
        logic                   ovf;
    } t_verdict;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_opcode;
    logic [LTR_W-1:0]       i_letter;
    logic                   i_last;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic                   o_matched;
    logic [COUNT_WIDTH-1:0] o_match_count;
    logic                   o_text_overflow;

    t_letter  pending_q[$];
    t_verdict verdict_q[$];

    // stimulus generator bookkeeping
    logic [LTR_W-1:0] gen_text [MAX_TEXT];
    int               gen_len;
    int               n_gen;
    bit               counting;

    // predictor state
    logic [LTR_W-1:0]       txt_mem [MAX_TEXT];
    int                     txt_len   = 0;
    bit                     txt_done  = 1'b1;
    int                     wpos      = 0;
    bit                     wfail     = 1'b0;
    logic [COUNT_WIDTH-1:0] hits      = '0;
    bit                     ovf       = 1'b0;

    int cycles     = 0;
    int errors     = 0;
    int n_accepted = 0;
    int bound1;
    int bound2;
    bit in_taken   = 1'b0;

    subsequence_match_counter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_letter        (i_letter),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_matched       (o_matched),
        .o_match_count   (o_match_count),
        .o_text_overflow (o_text_overflow)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // mostly in-alphabet letters, a few out of range
    function automatic logic [LTR_W-1:0] pick_letter(input int span);
        if ($urandom_range(0, 99) < 4)
            return LTR_W'($urandom_range(ALPHABET, 31));
        return LTR_W'($urandom_range(0, span - 1));
    endfunction

    task automatic push_item(input logic op, input logic [LTR_W-1:0] ltr, input logic lst);
        t_letter it;
        it.op  = op;
        it.ltr = ltr;
        it.lst = lst;
        pending_q.insert(pending_q.size(), it);
        if (counting)
            n_gen++;
    endtask

    // text of len letters; optional stray word letters mixed in, which the block ignores
    task automatic make_text(input int len, input int span, input bit noisy);
        logic [LTR_W-1:0] l;
        for (int i = 0; i < len; i++) begin
            if (noisy && i > 0 && $urandom_range(0, 99) < 15)
                push_item(OP_WORD, pick_letter(span), 1'($urandom_range(0, 1)));
            l = pick_letter(span);
            if (i < MAX_TEXT)
                gen_text[i] = l;
            push_item(OP_TEXT, l, i == len - 1);
        end
        gen_len = (len < MAX_TEXT) ? len : MAX_TEXT;
    endtask

    // word either drawn as a subsequence of the current text or of random letters
    task automatic make_word(input bit sub);
        logic [LTR_W-1:0] wq[$];
        int k;
        int pos;
        int hi;
        int j;
        k   = $urandom_range(1, 8);
        pos = 0;
        for (int i = 0; i < k; i++) begin
            if (sub) begin
                if (pos >= gen_len)
                    break;
                hi = (pos + 5 < gen_len) ? pos + 5 : gen_len - 1;
                j  = $urandom_range(hi, pos);
                wq.insert(wq.size(), gen_text[j]);
                pos = j + 1;
            end else begin
                wq.insert(wq.size(), pick_letter(6));
            end
        end
        foreach (wq[i])
            push_item(OP_WORD, wq[i], i == wq.size() - 1);
    endtask

    // predict the verdict of each accepted input word
    task automatic track_letter(input logic op, input logic [LTR_W-1:0] ltr, input logic lst);
        bit       found;
        t_verdict v;
        if (op == OP_TEXT) begin
            // a text letter after a finished text starts a new one
            if (txt_done) begin
                txt_done = 1'b0;
                txt_len  = 0;
                hits     = '0;
                ovf      = 1'b0;
            end
            wpos  = 0;
            wfail = 1'b0;
            if (txt_len < MAX_TEXT) begin
                txt_mem[txt_len] = ltr;
                txt_len++;
            end else begin
                ovf = 1'b1;
            end
            if (lst)
                txt_done = 1'b1;
        end else if (txt_done) begin
            // greedy scan from the position after the previous match
            if (!wfail) begin
                if (ltr >= ALPHABET || wpos >= txt_len) begin
                    wfail = 1'b1;
                end else begin
                    found = 1'b0;
                    for (int q = wpos; q < txt_len && !found; q++) begin
                        if (txt_mem[q] == ltr) begin
                            found = 1'b1;
                            wpos  = q + 1;
                        end
                    end
                    if (!found)
                        wfail = 1'b1;
                end
            end
            if (lst) begin
                v.matched = !wfail;
                if (!wfail && hits != '1)
                    hits++;
                v.count = hits;
                v.ovf   = ovf;
                verdict_q.insert(verdict_q.size(), v);
                wpos  = 0;
                wfail = 1'b0;
            end
        end
    endtask

    // sample both channels at the rising edge, check results, watch the cycle limit
    always @(posedge i_clk) begin
        t_verdict want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result word with no expectation waiting");
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_matched !== want.matched) begin
                        $error("matched: expected %0d, actual %0d", want.matched, o_matched);
                        errors++;
                    end
                    if (o_match_count !== want.count) begin
                        $error("match_count: expected %0d, actual %0d",
                               want.count, o_match_count);
                        errors++;
                    end
                    if (o_text_overflow !== want.ovf) begin
                        $error("text_overflow: expected %0d, actual %0d",
                               want.ovf, o_text_overflow);
                        errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                track_letter(i_opcode, i_letter, i_last);
                in_taken = 1'b1;
                n_accepted++;
            end
        end
    end

    // driver: present the next input word and set the output ready at the falling edge
    always @(negedge i_clk) begin
        t_letter nxt;
        bit      hold;
        int      s_idle;
        int      r_idle;
        if (i_rst_n) begin
            if (n_accepted < bound1) begin
                s_idle = 35;
                r_idle = 47;
            end else if (n_accepted < bound2) begin
                s_idle = 47;
                r_idle = 35;
            end else begin
                s_idle = 0;
                r_idle = 0;
            end
            hold     = i_in_valid && !in_taken;
            in_taken = 1'b0;
            if (!hold) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= s_idle) begin
                    nxt = pending_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_opcode   <= nxt.op;
                    i_letter   <= nxt.ltr;
                    i_last     <= nxt.lst;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= r_idle);
        end
    end

    initial begin
        int r;
        bit long_b;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_opcode    = 1'b0;
        i_letter    = '0;
        i_last      = 1'b0;
        i_out_ready = 1'b0;
        counting    = 1'b0;
        n_gen       = 0;
        long_b      = 1'b0;

        // directed: text "a z <out of alphabet> a"
        push_item(OP_TEXT, 5'd0, 1'b0);
        push_item(OP_TEXT, 5'd25, 1'b0);
        push_item(OP_TEXT, 5'd31, 1'b0);
        push_item(OP_TEXT, 5'd0, 1'b1);
        gen_text[0] = 5'd0;
        gen_text[1] = 5'd25;
        gen_text[2] = 5'd31;
        gen_text[3] = 5'd0;
        gen_len = 4;
        // single letter match, two letter match
        push_item(OP_WORD, 5'd0, 1'b1);
        push_item(OP_WORD, 5'd25, 1'b0);
        push_item(OP_WORD, 5'd0, 1'b1);
        // out of alphabet letter fails the word
        push_item(OP_WORD, 5'd31, 1'b1);
        push_item(OP_WORD, 5'd0, 1'b0);
        push_item(OP_WORD, 5'd0, 1'b1);
        // runs past the end of the text
        push_item(OP_WORD, 5'd0, 1'b0);
        push_item(OP_WORD, 5'd0, 1'b0);
        push_item(OP_WORD, 5'd0, 1'b1);
        // letter missing after the match
        push_item(OP_WORD, 5'd25, 1'b0);
        push_item(OP_WORD, 5'd25, 1'b1);
        // new text abandons a word in progress; word letter during load is ignored
        push_item(OP_WORD, 5'd0, 1'b0);
        push_item(OP_TEXT, 5'd1, 1'b0);
        push_item(OP_WORD, 5'd1, 1'b1);
        push_item(OP_TEXT, 5'd2, 1'b1);
        gen_text[0] = 5'd1;
        gen_text[1] = 5'd2;
        gen_len = 2;
        push_item(OP_WORD, 5'd1, 1'b0);
        push_item(OP_WORD, 5'd2, 1'b1);

        // random part: mostly subsequence words over short texts
        counting = 1'b1;
        while (n_gen < RAND_ITEMS) begin
            if (!long_b && n_gen > 400) begin
                // text filling the store and running past it, last mark on a dropped letter
                make_text(MAX_TEXT + 3, 5, 1'b0);
                repeat (6) make_word(1'b1);
                make_word(1'b0);
                long_b = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    make_text(($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                           : $urandom_range(1, 16),
                              ($urandom_range(0, 2) == 0) ? 2 :
                              ($urandom_range(0, 1) == 0) ? 5 : 26,
                              1'b1);
                end else if (r < 12) begin
                    repeat ($urandom_range(1, 3)) push_item(OP_WORD, pick_letter(26), 1'b0);
                    make_text($urandom_range(1, 12), 5, 1'b0);
                end else if (r < 80) begin
                    make_word(1'b1);
                end else begin
                    make_word(1'b0);
                end
            end
        end
        // finish on a word so no table build is left running
        make_word(1'b1);
        counting = 1'b0;

        bound1 = pending_q.size() / 3;
        bound2 = (pending_q.size() * 2) / 3;

        // reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain
        while (pending_q.size() > 0 || i_in_valid || verdict_q.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/smc_pkg.sv
rtl/smc_ram.sv
rtl/subsequence_match_counter.sv
verif/testbench.sv
